// ===== sv/bsil_pkg.sv =====
// package for the bounded sorted insert list
// holds sizes, status codes, opcodes, datapath commands and the datapath/controller status struct
package bsil_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 16;
   localparam int CFG_BITS = 7;
   localparam int ID_BITS = 6;
   localparam int OUT_KEY_BITS = 16;
   localparam int STATUS_BITS = 3;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;  // ignored, no result

   localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EVICTED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ENTRY = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_FRAME = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd6;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_START = 1'b1;

   // datapath commands
   localparam logic [3:0] CMD_NONE = 4'd0;
   localparam logic [3:0] CMD_LOAD = 4'd1;   // latch item, clamp window
   localparam logic [3:0] CMD_FRAME = 4'd2;  // reset window and seen mask
   localparam logic [3:0] CMD_PROBE = 4'd3;  // issue read of mid
   localparam logic [3:0] CMD_STEP = 4'd4;   // compare and narrow
   localparam logic [3:0] CMD_DECIDE = 4'd5; // pick placement
   localparam logic [3:0] CMD_RDEV = 4'd6;   // latch evicted last entry as result
   localparam logic [3:0] CMD_SHRD = 4'd7;   // read shift source
   localparam logic [3:0] CMD_SHWR = 4'd8;   // write shift target
   localparam logic [3:0] CMD_PLACE = 4'd9;  // write new entry
   localparam logic [3:0] CMD_LRD = 4'd10;   // read list entry
   localparam logic [3:0] CMD_LNEXT = 4'd11; // advance list pointer
   localparam logic [3:0] CMD_EMPTYW = 4'd12;// place into empty window

   typedef struct packed {
      logic dup;
      logic empty;
      logic search_done;
      logic reject;
      logic evict;
      logic direct;       // append or prepend, no shift
      logic shift_done;
      logic list_last;
   } status_type;

endpackage

// ===== sv/bounded_sorted_insert_list.sv =====
// Bounded sorted insert list. Sequential: one request at a time, the next one is taken only
// after the last result of the previous one has been accepted. A start frame, a duplicate
// and an insert into an empty window need no search. Any other insert runs a binary search
// of p probes (about log2(n) + 1, one slot-memory read each) and is then rejected or placed;
// when entries move, each shifted slot is read, waited for and written on the slot memory.
// The shorter side moves, but the side toward the open end when one end is blocked; an
// eviction first reads out the last entry. A readout gives one result per listed entry.
// Each result waits in the output register until taken. No clearing pass after reset.
module bounded_sorted_insert_list #(
   parameter int CAPACITY = bsil_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = bsil_pkg::KEY_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_opcode,
   input  logic [15:0] req_sort_key,
   input  logic [5:0] req_item_id,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_out_id,
   output logic [15:0] rsp_out_key,
   output logic rsp_last,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [6:0] csr_data
);
   logic [3:0] cmd;
   bsil_pkg::status_type stat;
   logic from_dp;
   logic [5:0] dp_id;
   logic [15:0] dp_key;

   bsil_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .stat, .cmd,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_last, .rsp_from_dp(from_dp)
   );

   bsil_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
      .clock, .reset, .cmd, .req_opcode, .req_sort_key, .req_item_id,
      .csr_write, .csr_index, .csr_data, .stat, .res_id(dp_id), .res_key(dp_key)
   );

   assign rsp_out_id = from_dp ? dp_id : '0;
   assign rsp_out_key = from_dp ? dp_key : '0;
endmodule

// ===== sv/bsil_datapath.sv =====
// datapath of the bounded sorted insert list: slot memory, window, search and shift
// depends on bsil_pkg
module bsil_datapath #(
   parameter int CAPACITY = bsil_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = bsil_pkg::KEY_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [3:0] cmd,
   input  logic [1:0] req_opcode,
   input  logic [bsil_pkg::OUT_KEY_BITS-1:0] req_sort_key,
   input  logic [bsil_pkg::ID_BITS-1:0] req_item_id,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [bsil_pkg::CFG_BITS-1:0] csr_data,
   output bsil_pkg::status_type stat,
   output logic [bsil_pkg::ID_BITS-1:0] res_id,
   output logic [bsil_pkg::OUT_KEY_BITS-1:0] res_key
);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
   localparam int CW = bsil_pkg::CFG_BITS;

   logic [KEY_BITS-1:0] keys_mem [CAPACITY];
   logic [bsil_pkg::ID_BITS-1:0] ids_mem [CAPACITY];

   logic [CW-1:0] cap_cfg_ff, start_cfg_ff;
   logic [PW-1:0] left_ff, left_in, right_ff, right_in;
   logic [63:0] seen_ff, seen_in;
   logic [PW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [KEY_BITS-1:0] key_ff, rd_key_ff, hold_key_ff;
   logic [bsil_pkg::ID_BITS-1:0] id_ff, rd_id_ff, hold_id_ff;
   logic dup_ff, grow_low_ff, grow_low_in;
   logic [bsil_pkg::ID_BITS-1:0] res_id_ff, res_id_in;
   logic [bsil_pkg::OUT_KEY_BITS-1:0] res_key_ff, res_key_in;

   // effective capacity and start
   logic [PW-1:0] ecap, estart;
   always_comb begin
      if (cap_cfg_ff == '0) ecap = PW'(1);
      else if ({1'b0, cap_cfg_ff} > (CW+1)'(CAPACITY)) ecap = CAP_P;
      else ecap = PW'(cap_cfg_ff);
      if ({1'b0, start_cfg_ff} > (CW+1)'(ecap)) estart = ecap;
      else estart = PW'(start_cfg_ff);
   end

   // clamped window as seen at load
   logic [PW-1:0] cr, cl;
   always_comb begin
      cr = (right_ff > ecap) ? ecap : right_ff;
      cl = (left_ff > cr) ? cr : left_ff;
   end

   logic [PW-1:0] mid;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   logic no_left, right_full;
   assign no_left = (left_ff == '0);
   assign right_full = (right_ff >= ecap);

   // memory ports: one read, one write per cycle
   logic [PW-1:0] rd_addr, wr_addr;
   logic wr_en;
   logic [KEY_BITS-1:0] wr_key;
   logic [bsil_pkg::ID_BITS-1:0] wr_id;

   always_comb begin
      rd_addr = mid;
      wr_en = 1'b0;
      wr_addr = ptr_ff;
      wr_key = rd_key_ff;
      wr_id = rd_id_ff;
      left_in = left_ff;
      right_in = right_ff;
      seen_in = seen_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      grow_low_in = grow_low_ff;
      res_id_in = res_id_ff;
      res_key_in = res_key_ff;
      case (cmd)
         bsil_pkg::CMD_LOAD: begin
            // a repeated id leaves the window as it is
            if (req_opcode == bsil_pkg::OP_READ || !seen_ff[req_item_id]) begin
               right_in = cr;
               left_in = cl;
            end
            lo_in = cl;
            hi_in = cr;
            ptr_in = cl;
            res_id_in = '0;
            res_key_in = '0;
            if (req_opcode == bsil_pkg::OP_INSERT && !seen_ff[req_item_id])
               seen_in = seen_ff | (64'd1 << req_item_id);
         end
         bsil_pkg::CMD_FRAME: begin
            left_in = estart;
            right_in = estart;
            seen_in = '0;
         end
         bsil_pkg::CMD_PROBE: rd_addr = mid;
         bsil_pkg::CMD_STEP: begin
            if (key_ff < rd_key_ff) hi_in = mid;
            else lo_in = mid + PW'(1);
         end
         bsil_pkg::CMD_DECIDE: begin
            // lo is the insertion index
            if (no_left && right_full) begin
               right_in = right_ff - PW'(1);
               rd_addr = right_ff - PW'(1);
               grow_low_in = 1'b0;
               ptr_in = right_ff - PW'(1);
            end else begin
               grow_low_in = right_full ||
                  (((lo_ff - left_ff) <= (right_ff - lo_ff)) && !no_left);
               if (right_full ||
                  (((lo_ff - left_ff) <= (right_ff - lo_ff)) && !no_left))
                  ptr_in = left_ff - PW'(1);
               else
                  ptr_in = right_ff;
            end
         end
         bsil_pkg::CMD_RDEV: begin
            res_id_in = hold_id_ff;
            res_key_in = bsil_pkg::OUT_KEY_BITS'(hold_key_ff);
            ptr_in = right_ff;
         end
         bsil_pkg::CMD_SHRD: begin
            rd_addr = grow_low_ff ? ptr_ff + PW'(1) : ptr_ff - PW'(1);
         end
         bsil_pkg::CMD_SHWR: begin
            wr_en = 1'b1;
            wr_addr = ptr_ff;
            wr_key = hold_key_ff;
            wr_id = hold_id_ff;
            ptr_in = grow_low_ff ? ptr_ff + PW'(1) : ptr_ff - PW'(1);
         end
         bsil_pkg::CMD_PLACE: begin
            wr_en = 1'b1;
            wr_key = key_ff;
            wr_id = id_ff;
            if (grow_low_ff) begin
               wr_addr = lo_ff - PW'(1);
               left_in = left_ff - PW'(1);
            end else begin
               wr_addr = lo_ff;
               right_in = right_ff + PW'(1);
            end
         end
         bsil_pkg::CMD_EMPTYW: begin
            wr_en = 1'b1;
            wr_key = key_ff;
            wr_id = id_ff;
            if (left_ff >= ecap) begin
               wr_addr = ecap - PW'(1);
               left_in = ecap - PW'(1);
               right_in = ecap;
            end else begin
               wr_addr = left_ff;
               right_in = right_ff + PW'(1);
            end
         end
         bsil_pkg::CMD_LRD: rd_addr = ptr_ff;
         bsil_pkg::CMD_LNEXT: begin
            res_id_in = rd_id_ff;
            res_key_in = bsil_pkg::OUT_KEY_BITS'(rd_key_ff);
            ptr_in = ptr_ff + PW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= keys_mem[rd_addr[AW-1:0]];
      rd_id_ff <= ids_mem[rd_addr[AW-1:0]];
      if (wr_en) begin
         keys_mem[wr_addr[AW-1:0]] <= wr_key;
         ids_mem[wr_addr[AW-1:0]] <= wr_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_cfg_ff <= CW'(64);
         start_cfg_ff <= CW'(32);
         left_ff <= (PW'(32) > CAP_P) ? CAP_P : PW'(32);
         right_ff <= (PW'(32) > CAP_P) ? CAP_P : PW'(32);
         seen_ff <= '0;
      end else begin
         if (csr_write && csr_index == bsil_pkg::CSR_CAPACITY) cap_cfg_ff <= csr_data;
         if (csr_write && csr_index == bsil_pkg::CSR_START) start_cfg_ff <= csr_data;
         left_ff <= left_in;
         right_ff <= right_in;
         seen_ff <= seen_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      grow_low_ff <= grow_low_in;
      res_id_ff <= res_id_in;
      res_key_ff <= res_key_in;
      // read data registered once more, used after the wait states
      hold_key_ff <= rd_key_ff;
      hold_id_ff <= rd_id_ff;
      if (cmd == bsil_pkg::CMD_LOAD) begin
         key_ff <= KEY_BITS'(req_sort_key);
         id_ff <= req_item_id;
         dup_ff <= seen_ff[req_item_id];
      end
   end

   always_comb begin
      stat.dup = dup_ff;
      stat.empty = (left_ff == right_ff);
      stat.search_done = (lo_ff >= hi_ff);
      stat.reject = no_left && right_full && (lo_ff == right_ff);
      stat.evict = no_left && right_full;
      stat.direct = (!right_full && lo_ff == right_ff) || (!no_left && lo_ff == left_ff);
      stat.shift_done = grow_low_ff ? (ptr_ff + PW'(1) >= lo_ff) : (ptr_ff <= lo_ff);
      stat.list_last = (ptr_ff + PW'(1) == right_ff);
   end

   // direct placement flag is folded into grow_low at decide via the placement command
   assign res_id = res_id_ff;
   assign res_key = res_key_ff;
endmodule

// ===== sv/bsil_control.sv =====
// controller state machine of the bounded sorted insert list
// depends on bsil_pkg; drives bsil_datapath commands
module bsil_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_opcode,
   input  bsil_pkg::status_type stat,
   output logic [3:0] cmd,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [bsil_pkg::STATUS_BITS-1:0] rsp_status,
   output logic rsp_last,
   output logic rsp_from_dp
);
   localparam logic [3:0] S_IDLE = 4'd0, S_LOADED = 4'd1, S_PROBE = 4'd2, S_STEP = 4'd3,
      S_DECIDE = 4'd4, S_EVRD = 4'd5, S_SHRD = 4'd6, S_SHWAIT = 4'd7, S_SHWR = 4'd8,
      S_PLACE = 4'd9, S_RESP = 4'd10, S_LRD = 4'd11, S_LWAIT = 4'd12, S_LOUT = 4'd13,
      S_EVWAIT = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [1:0] op_ff;
   logic [bsil_pkg::STATUS_BITS-1:0] st_ff, st_in;
   logic last_ff, last_in, dp_ff, dp_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP) || (state_ff == S_LOUT);
   assign rsp_status = st_ff;
   assign rsp_last = last_ff;
   assign rsp_from_dp = dp_ff;

   always_comb begin
      state_in = state_ff;
      cmd = bsil_pkg::CMD_NONE;
      st_in = st_ff;
      last_in = last_ff;
      dp_in = dp_ff;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            dp_in = 1'b0;
            last_in = 1'b1;
            if (req_opcode == bsil_pkg::OP_START) begin
               cmd = bsil_pkg::CMD_FRAME;
               st_in = bsil_pkg::ST_FRAME;
               state_in = S_RESP;
            end else if (req_opcode == bsil_pkg::OP_INSERT ||
                         req_opcode == bsil_pkg::OP_READ) begin
               cmd = bsil_pkg::CMD_LOAD;
               state_in = S_LOADED;
            end
         end
         S_LOADED: begin
            if (op_ff == bsil_pkg::OP_READ) begin
               if (stat.empty) begin
                  st_in = bsil_pkg::ST_EMPTY;
                  state_in = S_RESP;
               end else state_in = S_LRD;
            end else if (stat.dup) begin
               st_in = bsil_pkg::ST_DUPLICATE;
               state_in = S_RESP;
            end else if (stat.empty) begin
               cmd = bsil_pkg::CMD_EMPTYW;
               st_in = bsil_pkg::ST_INSERTED;
               state_in = S_RESP;
            end else state_in = S_PROBE;
         end
         S_PROBE: begin
            if (stat.search_done) state_in = S_DECIDE;
            else begin
               cmd = bsil_pkg::CMD_PROBE;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd = bsil_pkg::CMD_STEP;
            state_in = S_PROBE;
         end
         S_DECIDE: begin
            st_in = bsil_pkg::ST_INSERTED;
            if (stat.reject) begin
               st_in = bsil_pkg::ST_REJECTED;
               state_in = S_RESP;
            end else if (stat.evict) begin
               cmd = bsil_pkg::CMD_DECIDE;
               st_in = bsil_pkg::ST_EVICTED;
               dp_in = 1'b1;
               state_in = S_EVWAIT;
            end else begin
               cmd = bsil_pkg::CMD_DECIDE;
               state_in = stat.direct ? S_PLACE : S_SHRD;
            end
         end
         S_EVWAIT: state_in = S_EVRD;
         S_EVRD: begin
            cmd = bsil_pkg::CMD_RDEV;
            state_in = S_SHRD;
         end
         S_SHRD: begin
            if (stat.shift_done) state_in = S_PLACE;
            else begin
               cmd = bsil_pkg::CMD_SHRD;
               state_in = S_SHWAIT;
            end
         end
         S_SHWAIT: state_in = S_SHWR;
         S_SHWR: begin
            cmd = bsil_pkg::CMD_SHWR;
            state_in = S_SHRD;
         end
         S_PLACE: begin
            cmd = bsil_pkg::CMD_PLACE;
            state_in = S_RESP;
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         S_LRD: begin
            cmd = bsil_pkg::CMD_LRD;
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            cmd = bsil_pkg::CMD_LNEXT;
            st_in = bsil_pkg::ST_ENTRY;
            dp_in = 1'b1;
            last_in = stat.list_last;
            state_in = S_LOUT;
         end
         S_LOUT: if (rsp_ready) state_in = last_ff ? S_IDLE : S_LRD;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      if (state_ff == S_IDLE) op_ff <= req_opcode;
      st_ff <= st_in;
      last_ff <= last_in;
      dp_ff <= dp_in;
   end
endmodule

// ===== sv/bsil_checker.sv =====
// port-level checker for bounded_sorted_insert_list and its bind
// depends on bsil_pkg status codes
module bsil_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [5:0] rsp_out_id,
   input logic rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");
   a_entry_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bsil_pkg::ST_ENTRY |-> rsp_last)
      else $error("single result without last");
   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bsil_pkg::ST_FRAME || rsp_status == bsil_pkg::ST_EMPTY)
      |-> rsp_out_id == '0)
      else $error("nonzero id on frame or empty");
endmodule

bind bounded_sorted_insert_list bsil_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_out_id, .rsp_last
);

// ===== bench/bounded_sorted_insert_list_test.sv =====
// testbench for the bounded sorted insert list: random and directed transfers with
// a scoreboard class that predicts each result; depends on bsil_pkg and the block itself
module bounded_sorted_insert_list_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0] status;
      logic [5:0] id;
      logic [15:0] key;
      logic last;
   } list_rsp_type;

   class list_scoreboard;
      logic [15:0] slot_key [64];
      logic [5:0] slot_id [64];
      int wl, wr;
      logic [63:0] seen;
      logic [6:0] cap_reg, start_reg;
      list_rsp_type pending [$];
      int errors;

      function new();
         cap_reg = 7'd64;
         start_reg = 7'd32;
         wl = start_eff();
         wr = wl;
         seen = '0;
         errors = 0;
      endfunction

      function int cap_eff();
         int c;
         c = cap_reg;
         if (c < 1) c = 1;
         if (c > 64) c = 64;
         return c;
      endfunction

      function int start_eff();
         int s;
         s = start_reg;
         if (s > cap_eff()) s = cap_eff();
         return s;
      endfunction

      function void write_reg(logic index, logic [6:0] data);
         if (index == bsil_pkg::CSR_CAPACITY) cap_reg = data;
         else start_reg = data;
      endfunction

      function void clamp();
         if (wr > cap_eff()) wr = cap_eff();
         if (wl > wr) wl = wr;
      endfunction

      function void push(logic [2:0] st, logic [5:0] id, logic [15:0] key, logic last);
         list_rsp_type r;
         r.status = st;
         r.id = id;
         r.key = key;
         r.last = last;
         pending.push_back(r);
      endfunction

      function void place(int pos, logic [15:0] key, logic [5:0] id);
         slot_key[pos] = key;
         slot_id[pos] = id;
      endfunction

      function void insert_entry(logic [15:0] key, logic [5:0] id);
         int cap, lo, hi, mid, idx;
         bit no_left, right_full, go_left;
         logic [2:0] st;
         logic [5:0] ev_id;
         logic [15:0] ev_key;
         cap = cap_eff();
         st = bsil_pkg::ST_INSERTED;
         ev_id = '0;
         ev_key = '0;
         if (seen[id]) begin
            push(bsil_pkg::ST_DUPLICATE, '0, '0, 1'b1);
            return;
         end
         seen[id] = 1'b1;
         clamp();
         if (wl == wr) begin
            if (wl >= cap) begin
               wl = cap - 1;
               wr = cap - 1;
            end
            place(wl, key, id);
            wr++;
            push(bsil_pkg::ST_INSERTED, '0, '0, 1'b1);
            return;
         end
         no_left = (wl == 0);
         right_full = (wr >= cap);
         lo = wl;
         hi = wr;
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (key < slot_key[mid]) hi = mid;
            else lo = mid + 1;
         end
         idx = lo;
         if (no_left && right_full) begin
            if (idx == wr) begin
               push(bsil_pkg::ST_REJECTED, '0, '0, 1'b1);
               return;
            end
            wr--;
            ev_id = slot_id[wr];
            ev_key = slot_key[wr];
            st = bsil_pkg::ST_EVICTED;
            right_full = 0;
         end else if (!right_full && idx == wr) begin
            place(idx, key, id);
            wr++;
            push(bsil_pkg::ST_INSERTED, '0, '0, 1'b1);
            return;
         end else if (!no_left && idx == wl) begin
            wl--;
            place(wl, key, id);
            push(bsil_pkg::ST_INSERTED, '0, '0, 1'b1);
            return;
         end
         go_left = right_full || ((idx - wl) <= (wr - idx) && !no_left);
         if (go_left) begin
            for (int i = wl - 1; i + 1 < idx; i++) place(i, slot_key[i+1], slot_id[i+1]);
            wl--;
            place(idx - 1, key, id);
         end else begin
            for (int i = wr; i > idx; i--) place(i, slot_key[i-1], slot_id[i-1]);
            wr++;
            place(idx, key, id);
         end
         push(st, ev_id, ev_key, 1'b1);
      endfunction

      // an accepted request transfer
      function void note_request(logic [1:0] op, logic [15:0] key, logic [5:0] id);
         if (op == bsil_pkg::OP_START) begin
            wl = start_eff();
            wr = wl;
            seen = '0;
            push(bsil_pkg::ST_FRAME, '0, '0, 1'b1);
         end else if (op == bsil_pkg::OP_INSERT) begin
            insert_entry(key, id);
         end else if (op == bsil_pkg::OP_READ) begin
            clamp();
            if (wl == wr) push(bsil_pkg::ST_EMPTY, '0, '0, 1'b1);
            else
               for (int i = wl; i < wr; i++)
                  push(bsil_pkg::ST_ENTRY, slot_id[i], slot_key[i], i + 1 == wr);
         end
      endfunction

      // an accepted response transfer
      function void check_response(list_rsp_type got);
         list_rsp_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response status %0d", got.status);
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status || got.id !== exp.id || got.key !== exp.key ||
             got.last !== exp.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp %0d/%0d/%h/%b got %0d/%0d/%h/%b",
                        exp.status, exp.id, exp.key, exp.last,
                        got.status, got.id, got.key, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = '0;
   logic [15:0] req_sort_key = '0;
   logic [5:0] req_item_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [5:0] rsp_out_id;
   logic [15:0] rsp_out_key;
   logic rsp_last;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [6:0] csr_data = '0;

   list_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   bounded_sorted_insert_list u_top (.*);

   always #4 clock = ~clock;

   // response side: check, randomize ready, watchdog
   always @(posedge clock) begin
      list_rsp_type got;
      if (rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.id = rsp_out_id;
         got.key = rsp_out_key;
         got.last = rsp_last;
         sb.check_response(got);
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send(logic [1:0] op, logic [15:0] key, logic [5:0] id);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_sort_key <= key;
      req_item_id <= id;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, key, id);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      // an ignored opcode gives no response, so let the block settle
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [6:0] data);
      drain();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      sb.write_reg(index, data);
      csr_write <= 1'b0;
   endtask

   task automatic random_phase(int n, logic [6:0] cap, logic [6:0] start, int mode);
      int r;
      logic [15:0] key;
      write_csr(bsil_pkg::CSR_CAPACITY, cap);
      write_csr(bsil_pkg::CSR_START, start);
      send_idle_pct = (mode == 1 || mode == 3) ? 66 : 0;
      recv_stall_pct = (mode == 2) ? 66 : (mode == 3) ? 34 : 0;
      if (mode == 3) send_idle_pct = 34;
      send(bsil_pkg::OP_START, 16'($urandom), 6'($urandom));
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         key = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 15));
         if (r < 84) send(bsil_pkg::OP_INSERT, key, 6'($urandom_range(0, 63)));
         else if (r < 92) send(bsil_pkg::OP_READ, 16'($urandom), 6'($urandom));
         else if (r < 97) send(bsil_pkg::OP_START, 16'($urandom), 6'($urandom));
         else send(bsil_pkg::OP_UNUSED, 16'($urandom), 6'($urandom));
         if (mode == 2 && k == n / 2) drain();
      end
      send(bsil_pkg::OP_READ, '0, '0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, extremes, duplicates, equal keys
      send(bsil_pkg::OP_READ, 16'hffff, 6'd63);
      send(bsil_pkg::OP_UNUSED, 16'h1234, 6'd9);
      send(bsil_pkg::OP_START, '0, '0);
      send(bsil_pkg::OP_INSERT, 16'h0000, 6'd0);
      send(bsil_pkg::OP_INSERT, 16'hffff, 6'd63);
      send(bsil_pkg::OP_INSERT, 16'h8000, 6'd5);
      send(bsil_pkg::OP_INSERT, 16'h1111, 6'd5);
      send(bsil_pkg::OP_INSERT, 16'h8000, 6'd7);
      send(bsil_pkg::OP_READ, '0, '0);
      // empty window at the top slot, then full list: reject and evict
      write_csr(bsil_pkg::CSR_CAPACITY, 7'd3);
      write_csr(bsil_pkg::CSR_START, 7'd3);
      send(bsil_pkg::OP_START, '0, '0);
      send(bsil_pkg::OP_INSERT, 16'd10, 6'd1);
      send(bsil_pkg::OP_INSERT, 16'd5, 6'd2);
      send(bsil_pkg::OP_INSERT, 16'd7, 6'd3);
      send(bsil_pkg::OP_INSERT, 16'd20, 6'd4);
      send(bsil_pkg::OP_INSERT, 16'd1, 6'd4);
      send(bsil_pkg::OP_INSERT, 16'd1, 6'd6);
      send(bsil_pkg::OP_READ, '0, '0);
      // capacity lowered mid-frame cuts the window
      write_csr(bsil_pkg::CSR_CAPACITY, 7'd64);
      write_csr(bsil_pkg::CSR_START, 7'd0);
      send(bsil_pkg::OP_START, '0, '0);
      for (int i = 0; i < 5; i++) send(bsil_pkg::OP_INSERT, 16'(100 - i * 10), 6'(20 + i));
      write_csr(bsil_pkg::CSR_CAPACITY, 7'd2);
      send(bsil_pkg::OP_READ, '0, '0);
      send(bsil_pkg::OP_INSERT, 16'd50, 6'd30);
      send(bsil_pkg::OP_READ, '0, '0);

      random_phase(36, 7'd64, 7'd32, 0);
      random_phase(36, 7'd4, 7'd2, 1);
      random_phase(36, 7'd1, 7'd0, 2);
      random_phase(36, 7'd0, 7'd127, 3);
      random_phase(36, 7'd64, 7'd0, 0);
      random_phase(36, 7'd127, 7'd64, 1);
      random_phase(36, 7'($urandom_range(2, 12)), 7'($urandom_range(0, 12)), 2);
      random_phase(36, 7'($urandom_range(1, 64)), 7'($urandom_range(0, 64)), 3);

      drain();
      sb.errors += sb.pending.size();
      if (sb.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
